>>> hw/rtl/phdh_pkg.sv
// ----------------------------------------------------------------------------
// phdh_pkg
// Shared widths, configuration register codes and helpers for the pair
// displacement histogram.
// ----------------------------------------------------------------------------
package phdh_pkg;

  localparam int GRID_W   = 5;
  localparam int BIN_W    = 4;
  localparam int IDX_W    = 12;
  localparam int SUM_W    = 48;
  localparam int WEIGHT_W = 16;
  localparam int DISP_W   = 24;
  localparam int COEF_W   = 20;
  localparam int ROW_W    = 60;
  localparam int FRAC_W   = 30;
  localparam int PROD_W   = COEF_W + DISP_W;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW_Z = 3'd5;

  // Effective bin counts per axis, each 1..16
  typedef struct packed {
    logic [GRID_W-1:0] gx;
    logic [GRID_W-1:0] gy;
    logic [GRID_W-1:0] gz;
  } grid_t;

  // Zero acts as one, anything above sixteen as sixteen
  function automatic logic [GRID_W-1:0] eff_grid(input logic [GRID_W-1:0] g);
    logic [GRID_W-1:0] r;
    if (g == '0) begin
      r = 5'd1;
    end else if (g > 5'd16) begin
      r = 5'd16;
    end else begin
      r = g;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/phdh_ram.sv
// ----------------------------------------------------------------------------
// phdh_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module phdh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/phdh_index.sv
// ----------------------------------------------------------------------------
// phdh_index
// Maps one displacement to a flat histogram bin: one lattice row per pass
// through three shared multipliers, then wrap, scale and index combine.
// ----------------------------------------------------------------------------
module phdh_index #(
  parameter int DIMS = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [phdh_pkg::DISP_W-1:0] disp_x,
  input  logic signed [phdh_pkg::DISP_W-1:0] disp_y,
  input  logic signed [phdh_pkg::DISP_W-1:0] disp_z,
  input  phdh_pkg::grid_t                   grids,
  input  logic [phdh_pkg::ROW_W-1:0]        row_x,
  input  logic [phdh_pkg::ROW_W-1:0]        row_y,
  input  logic [phdh_pkg::ROW_W-1:0]        row_z,
  output logic                              done,
  output logic [phdh_pkg::IDX_W-1:0]        idx
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_BIN, S_COMB, S_FINAL} state_t;

  localparam logic [1:0] LAST_AXIS = (DIMS == 2) ? 2'd1 : 2'd2;

  state_t                            state;
  logic [1:0]                        axis;
  logic signed [phdh_pkg::DISP_W-1:0] dx, dy, dz;
  logic [phdh_pkg::FRAC_W-1:0]       prod0, prod1, prod2;
  logic [phdh_pkg::BIN_W-1:0]        bx, by, bz;
  logic [7:0]                        part;

  logic [phdh_pkg::ROW_W-1:0]         row_sel;
  logic [phdh_pkg::GRID_W-1:0]        g_sel;
  logic signed [phdh_pkg::COEF_W-1:0] c0, c1, c2;
  logic signed [phdh_pkg::PROD_W-1:0] p0_full, p1_full, p2_full;
  logic [phdh_pkg::FRAC_W-1:0]        frac;
  logic [34:0]                        scaled;
  logic [phdh_pkg::BIN_W-1:0]         bin_new;
  logic [phdh_pkg::GRID_W-1:0]        gz_use;
  logic [8:0]                         part_sum;
  logic [12:0]                        idx_sum;

  always_comb begin
    case (axis)
      2'd0: begin
        row_sel = row_x;
        g_sel   = grids.gx;
      end
      2'd1: begin
        row_sel = row_y;
        g_sel   = grids.gy;
      end
      2'd2: begin
        row_sel = row_z;
        g_sel   = grids.gz;
      end
      default: begin
        row_sel = '0;
        g_sel   = 5'd1;
      end
    endcase
  end

  assign c0 = row_sel[19:0];
  assign c1 = row_sel[39:20];
  assign c2 = row_sel[59:40];

  assign p0_full = c0 * dx;
  assign p1_full = c1 * dy;
  assign p2_full = c2 * dz;

  // Keeping the low fraction bits of the sum is the floor wrap into [0,1)
  assign frac    = prod0 + prod1 + prod2;
  assign scaled  = 35'(g_sel) * 35'(frac);
  assign bin_new = scaled[33:30];

  assign gz_use   = (DIMS == 2) ? 5'd1 : grids.gz;
  assign part_sum = 9'(bx) * 9'(grids.gy) + 9'(by);
  assign idx_sum  = 13'(part) * 13'(gz_use) + 13'(bz);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      axis  <= 2'd0;
    end else begin
      done <= (state == S_FINAL);
      case (state)
        S_IDLE: begin
          if (start) begin
            dx    <= disp_x;
            dy    <= disp_y;
            dz    <= (DIMS == 2) ? '0 : disp_z;
            bz    <= '0;
            axis  <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod0 <= p0_full[phdh_pkg::FRAC_W-1:0];
          prod1 <= p1_full[phdh_pkg::FRAC_W-1:0];
          prod2 <= p2_full[phdh_pkg::FRAC_W-1:0];
          state <= S_BIN;
        end
        S_BIN: begin
          case (axis)
            2'd0:    bx <= bin_new;
            2'd1:    by <= bin_new;
            default: bz <= bin_new;
          endcase
          if (axis == LAST_AXIS) begin
            state <= S_COMB;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_MUL;
          end
        end
        S_COMB: begin
          part  <= part_sum[7:0];
          state <= S_FINAL;
        end
        S_FINAL: begin
          idx   <= idx_sum[phdh_pkg::IDX_W-1:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/pair_displacement_histogram_core.sv
// ----------------------------------------------------------------------------
// pair_displacement_histogram_core
// Periodic pair displacement histogram with saturating weighted bins.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per pair: tuser is the action (0 accumulate,
//   1 read and clear), tdata holds the displacement, weight and read bin.
//   m_axis returns one item per input item: bin index, bin value and the
//   saturation flag.
//   Configuration registers (grids and inverse lattice rows) are written
//   through cfg_we / cfg_index / cfg_data while the block is idle.
// Timing:
//   An accumulate item passes, from accept to result, one row multiply and
//   one wrap-and-scale step per axis in the index unit, two index combine
//   steps and one handoff step, then a histogram read and a write. A read
//   item goes straight to the histogram read and write. One item is in
//   flight at a time; the next item can be accepted from the cycle after
//   the previous one reaches the output register.
// Reset:
//   rst resets control and config registers. The histogram is then zeroed
//   by writing all MAX_BINS bins, during which s_axis_tready stays low.
// Stall:
//   While m_axis_tready is low the result holds in the output register; a
//   following item is taken in but holds before its write back.
// ----------------------------------------------------------------------------
module pair_displacement_histogram_core #(
  parameter int MAX_BINS = 4096,
  parameter int DIMS     = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  // disp_x[23:0], disp_y[47:24], disp_z[71:48], weight[87:72],
  // read_bin[99:88], zero fill
  input  logic [103:0]                      s_axis_tdata,
  // action[0]
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // bin_index[11:0], bin_value[59:12], saturated[60], zero fill
  output logic [63:0]                       m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we,
  input  logic [phdh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [phdh_pkg::ROW_W-1:0]        cfg_data
);

  localparam int ADDR_W = $clog2(MAX_BINS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BINS - 1);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_CALC, ST_READ, ST_WRITE} state_t;

  state_t                              state;
  logic [ADDR_W-1:0]                   clr_addr;
  logic                                action;
  logic [phdh_pkg::WEIGHT_W-1:0]       weight;
  logic [phdh_pkg::IDX_W-1:0]          idx;
  logic [phdh_pkg::GRID_W-1:0]         grid_x, grid_y, grid_z;
  logic [phdh_pkg::ROW_W-1:0]          inv_row_x, inv_row_y, inv_row_z;

  phdh_pkg::grid_t                     grids;
  logic                                idx_start;
  logic                                idx_done;
  logic [phdh_pkg::IDX_W-1:0]          idx_calc;
  logic                                in_range;
  logic [31:0]                         idx_wide;
  logic [ADDR_W-1:0]                   addr;
  logic                                out_free;
  logic [phdh_pkg::SUM_W-1:0]          rd_data;
  logic [phdh_pkg::SUM_W:0]            sum;
  logic                                sat_next;
  logic [phdh_pkg::SUM_W-1:0]          val_next;
  logic [phdh_pkg::SUM_W-1:0]          wb_data;
  logic                                ram_we;
  logic [ADDR_W-1:0]                   ram_waddr;
  logic [phdh_pkg::SUM_W-1:0]          ram_wdata;

  assign grids.gx = phdh_pkg::eff_grid(grid_x);
  assign grids.gy = phdh_pkg::eff_grid(grid_y);
  assign grids.gz = phdh_pkg::eff_grid(grid_z);

  assign s_axis_tready = (state == ST_IDLE);
  assign idx_start     = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign idx_wide = 32'(idx);
  assign in_range = idx_wide < 32'(MAX_BINS);
  assign addr     = idx_wide[ADDR_W-1:0];

  // Saturating add for accumulate, plain pass-through for read
  assign sum      = {1'b0, rd_data} + 49'(weight);
  assign sat_next = !action && sum[phdh_pkg::SUM_W];
  assign val_next = action ? rd_data :
                    (sat_next ? {phdh_pkg::SUM_W{1'b1}} : sum[phdh_pkg::SUM_W-1:0]);
  assign wb_data  = action ? '0 : val_next;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = wb_data;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_WRITE: ram_we = out_free && in_range;
      default:  ram_we = 1'b0;
    endcase
  end

  phdh_index #(.DIMS(DIMS)) u_index (
    .clk    (clk),
    .rst    (rst),
    .start  (idx_start),
    .disp_x (s_axis_tdata[23:0]),
    .disp_y (s_axis_tdata[47:24]),
    .disp_z (s_axis_tdata[71:48]),
    .grids  (grids),
    .row_x  (inv_row_x),
    .row_y  (inv_row_y),
    .row_z  (inv_row_z),
    .done   (idx_done),
    .idx    (idx_calc)
  );

  phdh_ram #(.WIDTH(phdh_pkg::SUM_W), .DEPTH(MAX_BINS)) u_hist (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (state == ST_READ),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x    <= 5'd1;
      grid_y    <= 5'd1;
      grid_z    <= 5'd1;
      inv_row_x <= '0;
      inv_row_y <= '0;
      inv_row_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        phdh_pkg::CFG_GRID_X:    grid_x    <= cfg_data[phdh_pkg::GRID_W-1:0];
        phdh_pkg::CFG_GRID_Y:    grid_y    <= cfg_data[phdh_pkg::GRID_W-1:0];
        phdh_pkg::CFG_GRID_Z:    grid_z    <= cfg_data[phdh_pkg::GRID_W-1:0];
        phdh_pkg::CFG_INV_ROW_X: inv_row_x <= cfg_data;
        phdh_pkg::CFG_INV_ROW_Y: inv_row_y <= cfg_data;
        phdh_pkg::CFG_INV_ROW_Z: inv_row_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // drop a taken result unless the write back reloads the register
      if (m_axis_tvalid && m_axis_tready && state != ST_WRITE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            action <= s_axis_tuser;
            weight <= s_axis_tdata[87:72];
            idx    <= s_axis_tdata[99:88];
            state  <= s_axis_tuser ? ST_READ : ST_CALC;
          end
        end
        ST_CALC: begin
          if (idx_done) begin
            idx   <= idx_calc;
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_WRITE;
        ST_WRITE: begin
          // hold until the output register can take the result
          if (out_free) begin
            m_axis_tvalid        <= 1'b1;
            m_axis_tdata[11:0]   <= idx;
            m_axis_tdata[59:12]  <= in_range ? val_next : '0;
            m_axis_tdata[60]     <= in_range && sat_next;
            m_axis_tdata[63:61]  <= '0;
            state                <= ST_IDLE;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[60]) |-> (m_axis_tdata[59:12] == {48{1'b1}}))
    else $error("saturated result without full-scale value");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    idx_done |-> (state == ST_CALC))
    else $error("index unit finished outside calculation");

  a_write_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && out_free) |=> (m_axis_tvalid && state == ST_IDLE))
    else $error("write back did not load the output register");
`endif

endmodule

>>> bench/pair_displacement_histogram_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pair_displacement_histogram_core_test
// Self-checking bench for the pair displacement histogram. Displacements and
// read actions are streamed in with random gaps on both sides. A local
// histogram image predicts each returned bin, its sum and the clip flag.
// The lattice and grid settings change between traffic phases.
// ----------------------------------------------------------------------------
module pair_displacement_histogram_core_test;

  localparam int NUM_BINS = 4096;
  localparam int NUM_DIMS = 3;
  localparam logic [phdh_pkg::SUM_W-1:0] SUM_TOP = '1;

  typedef enum logic {
    ACT_ACCUMULATE = 1'b0,
    ACT_READ       = 1'b1
  } action_t;

  typedef struct {
    action_t                         action;
    logic [phdh_pkg::DISP_W-1:0]     dx;
    logic [phdh_pkg::DISP_W-1:0]     dy;
    logic [phdh_pkg::DISP_W-1:0]     dz;
    logic [phdh_pkg::WEIGHT_W-1:0]   weight;
    logic [phdh_pkg::IDX_W-1:0]      read_bin;
  } pair_item_t;

  typedef struct {
    logic [phdh_pkg::IDX_W-1:0] idx;
    logic [phdh_pkg::SUM_W-1:0] value;
    logic                       sat;
  } bin_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic [103:0]                   s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [63:0]                    m_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [phdh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [phdh_pkg::ROW_W-1:0]     cfg_data = '0;

  // Local image of the block: histogram and register values
  logic [phdh_pkg::SUM_W-1:0]  hist_mem [NUM_BINS];
  logic [phdh_pkg::GRID_W-1:0] grid_cfg [3];
  logic [phdh_pkg::ROW_W-1:0]  row_cfg [3];

  pair_item_t  pending_items [$];
  bin_result_t expected_bins [$];
  int          recent_bins [$];

  logic s_took = 1'b0;
  bit   gaps_on = 1'b1;
  bit   long_hold_done = 1'b0;
  int   tx_gap = 0;
  int   rx_hold = 0;
  int   results_seen = 0;
  int   mismatch_count = 0;

  pair_displacement_histogram_core #(
    .MAX_BINS(NUM_BINS),
    .DIMS    (NUM_DIMS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int grid_bins(logic [phdh_pkg::GRID_W-1:0] g);
    if (g == '0) return 1;
    if (g > 5'd16) return 16;
    return int'(g);
  endfunction

  // Fractional coordinate along one axis, floor-wrapped, then scaled to g bins
  function automatic int axis_bin(logic [phdh_pkg::ROW_W-1:0] row,
                                  logic [phdh_pkg::DISP_W-1:0] dx,
                                  logic [phdh_pkg::DISP_W-1:0] dy,
                                  logic [phdh_pkg::DISP_W-1:0] dz, int g);
    longint     acc;
    logic [35:0] scaled;
    acc = longint'($signed(row[19:0])) * longint'($signed(dx))
        + longint'($signed(row[39:20])) * longint'($signed(dy))
        + longint'($signed(row[59:40])) * longint'($signed(dz));
    scaled = 36'(g) * {6'b0, acc[phdh_pkg::FRAC_W-1:0]};
    return int'(scaled[35:phdh_pkg::FRAC_W]);
  endfunction

  function automatic int bin_of(logic [phdh_pkg::DISP_W-1:0] dx,
                                logic [phdh_pkg::DISP_W-1:0] dy,
                                logic [phdh_pkg::DISP_W-1:0] dz);
    int gx, gy, gz, idx;
    gx = grid_bins(grid_cfg[0]);
    gy = grid_bins(grid_cfg[1]);
    gz = grid_bins(grid_cfg[2]);
    if (NUM_DIMS == 2) begin
      dz = '0;
      gz = 1;
    end
    idx = axis_bin(row_cfg[0], dx, dy, dz, gx) * gy
        + axis_bin(row_cfg[1], dx, dy, dz, gy);
    idx = idx * gz;
    if (NUM_DIMS != 2) idx += axis_bin(row_cfg[2], dx, dy, dz, gz);
    return idx;
  endfunction

  // Apply one item to the histogram image and return the bin it reports
  function automatic bin_result_t histogram_step(action_t act, logic [103:0] data);
    bin_result_t  r;
    int           idx;
    logic [48:0]  sum;
    r.value = '0;
    r.sat   = 1'b0;
    if (act == ACT_READ) begin
      idx = int'(data[99:88]);
      if (idx < NUM_BINS) begin
        r.value = hist_mem[idx];
        hist_mem[idx] = '0;
      end
    end else begin
      idx = bin_of(data[23:0], data[47:24], data[71:48]);
      if (idx < NUM_BINS) begin
        sum = {1'b0, hist_mem[idx]} + 49'(data[87:72]);
        if (sum > {1'b0, SUM_TOP}) begin
          sum = {1'b0, SUM_TOP};
          r.sat = 1'b1;
        end
        hist_mem[idx] = sum[phdh_pkg::SUM_W-1:0];
        r.value = sum[phdh_pkg::SUM_W-1:0];
      end
    end
    r.idx = idx[phdh_pkg::IDX_W-1:0];
    return r;
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [phdh_pkg::DISP_W-1:0] rand_disp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h800000;
    if (r == 1) return 24'h7FFFFF;
    if (r < 6) return 24'($urandom());
    return 24'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [phdh_pkg::WEIGHT_W-1:0] rand_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return 16'($urandom());
  endfunction

  function automatic logic [phdh_pkg::COEF_W-1:0] rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 20'($urandom());
    if (r < 8) return 20'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    if (r == 8) return '0;
    return $urandom_range(0, 1) ? 20'h80000 : 20'h7FFFF;
  endfunction

  function automatic logic [phdh_pkg::ROW_W-1:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic [phdh_pkg::GRID_W-1:0] rand_grid();
    if ($urandom_range(0, 9) < 8) return 5'($urandom_range(1, 16));
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic write_reg(input logic [phdh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [phdh_pkg::ROW_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      phdh_pkg::CFG_GRID_X:    grid_cfg[0] = data[phdh_pkg::GRID_W-1:0];
      phdh_pkg::CFG_GRID_Y:    grid_cfg[1] = data[phdh_pkg::GRID_W-1:0];
      phdh_pkg::CFG_GRID_Z:    grid_cfg[2] = data[phdh_pkg::GRID_W-1:0];
      phdh_pkg::CFG_INV_ROW_X: row_cfg[0] = data;
      phdh_pkg::CFG_INV_ROW_Y: row_cfg[1] = data;
      phdh_pkg::CFG_INV_ROW_Z: row_cfg[2] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(input logic [phdh_pkg::GRID_W-1:0] gx,
                             input logic [phdh_pkg::GRID_W-1:0] gy,
                             input logic [phdh_pkg::GRID_W-1:0] gz,
                             input logic [phdh_pkg::ROW_W-1:0] rx,
                             input logic [phdh_pkg::ROW_W-1:0] ry,
                             input logic [phdh_pkg::ROW_W-1:0] rz);
    write_reg(phdh_pkg::CFG_GRID_X, phdh_pkg::ROW_W'(gx));
    write_reg(phdh_pkg::CFG_GRID_Y, phdh_pkg::ROW_W'(gy));
    write_reg(phdh_pkg::CFG_GRID_Z, phdh_pkg::ROW_W'(gz));
    write_reg(phdh_pkg::CFG_INV_ROW_X, rx);
    write_reg(phdh_pkg::CFG_INV_ROW_Y, ry);
    write_reg(phdh_pkg::CFG_INV_ROW_Z, rz);
  endtask

  // Hold until every queued item is taken and every result has come back
  task automatic wait_idle();
    @(posedge clk);
    #1;
    while (pending_items.size() != 0 || expected_bins.size() != 0 || s_axis_tvalid) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic queue_accumulate(input logic [phdh_pkg::DISP_W-1:0] dx,
                                  input logic [phdh_pkg::DISP_W-1:0] dy,
                                  input logic [phdh_pkg::DISP_W-1:0] dz,
                                  input logic [phdh_pkg::WEIGHT_W-1:0] w);
    pair_item_t it;
    it.action   = ACT_ACCUMULATE;
    it.dx       = dx;
    it.dy       = dy;
    it.dz       = dz;
    it.weight   = w;
    it.read_bin = 12'($urandom());
    pending_items.push_back(it);
    recent_bins.push_back(bin_of(dx, dy, dz));
    if (recent_bins.size() > 32) void'(recent_bins.pop_front());
  endtask

  task automatic queue_read(input logic [phdh_pkg::IDX_W-1:0] b);
    pair_item_t it;
    it.action   = ACT_READ;
    it.dx       = 24'($urandom());
    it.dy       = 24'($urandom());
    it.dz       = 24'($urandom());
    it.weight   = 16'($urandom());
    it.read_bin = b;
    pending_items.push_back(it);
  endtask

  task automatic queue_random_item();
    if ($urandom_range(0, 99) < 25) begin
      // mostly read back bins that were hit recently so sums are nonzero
      if (recent_bins.size() > 0 && $urandom_range(0, 2) != 0) begin
        queue_read(12'(recent_bins[$urandom_range(0, recent_bins.size() - 1)]));
      end else begin
        queue_read(12'($urandom_range(0, 4095)));
      end
    end else begin
      queue_accumulate(rand_disp(), rand_disp(), rand_disp(), rand_weight());
    end
  endtask

  // Sender
  always @(negedge clk) begin
    pair_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_took) begin
      // hold the offered item
    end else if (tx_gap > 0) begin
      tx_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      nxt = pending_items.pop_front();
      s_axis_tdata  <= {4'b0, nxt.read_bin, nxt.weight, nxt.dz, nxt.dy, nxt.dx};
      s_axis_tuser  <= nxt.action;
      s_axis_tvalid <= 1'b1;
      tx_gap = (gaps_on && $urandom_range(0, 2) == 0) ? stall_len() : 0;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 150) begin
      // long hold-off so the block backs up into its input
      long_hold_done = 1'b1;
      rx_hold = 300;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      rx_hold = stall_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Input and output monitor
  always @(posedge clk) begin
    bin_result_t want;
    if (rst) begin
      s_took <= 1'b0;
    end else begin
      s_took <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_bins.push_back(histogram_step(action_t'(s_axis_tuser), s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_bins.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result at %0t: bin %0d value %0d sat %0b", $realtime,
                     m_axis_tdata[11:0], m_axis_tdata[59:12], m_axis_tdata[60]);
          end
        end else begin
          want = expected_bins.pop_front();
          if (m_axis_tdata[11:0] !== want.idx || m_axis_tdata[59:12] !== want.value ||
              m_axis_tdata[60] !== want.sat) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch at %0t: expected %0d/%0d/%0b got %0d/%0d/%0b",
                       $realtime, want.idx, want.value, want.sat, m_axis_tdata[11:0],
                       m_axis_tdata[59:12], m_axis_tdata[60]);
            end
          end
        end
      end
    end
  end

  initial begin
    int ph;
    int n;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    grid_cfg[0] = 5'd1;
    grid_cfg[1] = 5'd1;
    grid_cfg[2] = 5'd1;
    row_cfg[0] = '0;
    row_cfg[1] = '0;
    row_cfg[2] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: zero matrix puts everything in bin 0
    queue_accumulate(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
    queue_accumulate(24'h800000, 24'h800000, 24'h800000, 16'h0000);
    queue_read(12'd0);
    queue_read(12'd0);
    queue_read(12'd4095);

    // Unit lattice on the full grid: wrap of negatives, extremes, half cell
    wait_idle();
    load_config(5'd16, 5'd16, 5'd16, {20'h0, 20'h0, 20'h40000},
                {20'h0, 20'h40000, 20'h0}, {20'h40000, 20'h0, 20'h0});
    queue_accumulate(24'h000000, 24'h000000, 24'h000000, 16'h0001);
    queue_accumulate(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    queue_accumulate(24'h800000, 24'h7FFFFF, 24'h001000, 16'h1234);
    queue_accumulate(24'h000800, 24'h000800, 24'h000800, 16'h00FF);
    queue_accumulate(24'h000800, 24'h000800, 24'h000800, 16'h0000);
    queue_read(12'd4095);
    queue_read(12'd2184);
    queue_read(12'd0);

    // Grid values outside 1..16 and extreme coefficients
    wait_idle();
    load_config(5'd0, 5'd31, 5'd17, {20'h7FFFF, 20'h80000, 20'h7FFFF},
                60'hFFF_FFFF_FFFF_FFFF, {20'h80000, 20'h80000, 20'h80000});
    queue_accumulate(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'hFFFF);
    queue_accumulate(24'h800000, 24'h800000, 24'h800000, 16'h8000);
    queue_accumulate(24'h123456, 24'hABCDEF, 24'h0F0F0F, 16'h0001);
    queue_read(12'(recent_bins[$]));
    queue_read(12'(recent_bins[0]));

    for (ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 0) begin
        load_config(5'd16, 5'd16, 5'd16, rand_row(), rand_row(), rand_row());
      end else if (ph == 1) begin
        load_config(5'd1, 5'd1, 5'd1, rand_row(), rand_row(), rand_row());
      end else begin
        load_config(rand_grid(), rand_grid(), rand_grid(), rand_row(), rand_row(),
                    rand_row());
      end
      gaps_on = (ph != 3);
      for (n = 0; n < 206; n++) queue_random_item();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/phdh_pkg.sv
hw/rtl/phdh_ram.sv
hw/rtl/phdh_index.sv
hw/rtl/pair_displacement_histogram_core.sv
bench/pair_displacement_histogram_core_test.sv
